// ===== sv/bpfa_pkg.sv =====
package bpfa_pkg;

    localparam int FRAMES_DEF  = 65536;
    localparam int CW          = 22;     // frame index / bound width in the scan datapath
    localparam int PAGE_SHIFT  = 12;
    localparam int HINT_RESET  = 256;
    localparam int FLOOR_RESET = 256;
    localparam int TRACK_RESET = 65536;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_FREE    = 2'd1;
    localparam logic [1:0] KIND_RESERVE = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_IGNORED = 2'd2;

    localparam logic [1:0] REG_FRAMES_TRACKED = 2'd0;
    localparam logic [1:0] REG_SEARCH_FLOOR   = 2'd1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_P1_RD,
        ST_P1_EV,
        ST_P2_RD,
        ST_P2_EV,
        ST_MARK,
        ST_OP_RD,
        ST_OP_EV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       load;
        logic       start_p1;
        logic       start_p2;
        logic       start_op;
        logic       ev_alloc;
        logic       ev_op;
        logic       mark_init;
        logic       mark_step;
        logic       clr_step;
        logic       finish;
        logic [1:0] fin_status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       ign;
        logic       p1_ok;
        logic       p2_ok;
        logic       f_end;
        logic       run_hit;
        logic       mark_last;
        logic       clr_last;
        logic       out_free;
    } dstat_t;

endpackage

// ===== sv/bitmap_page_frame_allocator_core.sv =====
// channel  | handshake               | beat contents
// item     | item_valid / item_stall | kind, address, page_count, byte_length
// result   | result_valid / result_stall | status, alloc_address, free_frames
// config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Allocate reads each scanned frame from the bitmap RAM and evaluates it, then
// marks the run frame by frame; a pass that misses closes in its read state. Free
// and reserve read and evaluate each frame, then close the range. Accept, decode
// and result hand-off use the IDLE, DISPATCH and FINISH states. One item is worked
// on at a time. After reset a clearing pass sets every frame taken; item_stall
// stays high until it ends. A stalled result holds in the output register.
module bitmap_page_frame_allocator_core
    import bpfa_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] address,
    input  logic [16:0] page_count,
    input  logic [32:0] byte_length,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic [31:0] alloc_address,
    output logic [16:0] free_frames,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    cmd_t   cmd;
    dstat_t dst;
    logic   busy;

    assign cfg_ready  = 1'b1;
    assign item_stall = busy;

    bpfa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .dst        (dst),
        .cmd        (cmd),
        .busy       (busy)
    );

    bpfa_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .dst           (dst),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .kind          (kind),
        .address       (address),
        .page_count    (page_count),
        .byte_length   (byte_length),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .alloc_address (alloc_address),
        .free_frames   (free_frames)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("block took a second item while working");

    a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != STAT_OK) |-> (alloc_address == 32'd0))
        else $error("nonzero address on failed or ignored item");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared without work in progress");

endmodule

// ===== sv/bpfa_ctrl.sv =====
module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    input  dstat_t dst,
    output cmd_t   cmd,
    output logic   busy
);

    state_t     state_reg, state_next;
    logic [1:0] stat_reg, stat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            stat_reg  <= STAT_OK;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        stat_next      = stat_reg;
        cmd            = '0;
        cmd.fin_status = stat_reg;
        busy           = (state_reg != ST_IDLE);
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (dst.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                stat_next  = STAT_OK;
                if (dst.ign)
                begin
                    stat_next  = STAT_IGNORED;
                    state_next = ST_FINISH;
                end
                else if (dst.kind == KIND_ALLOC)
                begin
                    if (dst.p1_ok)
                    begin
                        cmd.start_p1 = 1'b1;
                        state_next   = ST_P1_RD;
                    end
                    else if (dst.p2_ok)
                    begin
                        cmd.start_p2 = 1'b1;
                        state_next   = ST_P2_RD;
                    end
                    else
                    begin
                        stat_next  = STAT_FULL;
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    cmd.start_op = 1'b1;
                    state_next   = ST_OP_RD;
                end
            end
            ST_P1_RD:
            begin
                if (!dst.f_end)
                    state_next = ST_P1_EV;
                else if (dst.p2_ok)
                begin
                    cmd.start_p2 = 1'b1;
                    state_next   = ST_P2_RD;
                end
                else
                begin
                    stat_next  = STAT_FULL;
                    state_next = ST_FINISH;
                end
            end
            ST_P1_EV:
            begin
                if (dst.run_hit)
                begin
                    cmd.mark_init = 1'b1;
                    state_next    = ST_MARK;
                end
                else
                begin
                    cmd.ev_alloc = 1'b1;
                    state_next   = ST_P1_RD;
                end
            end
            ST_P2_RD:
            begin
                if (!dst.f_end)
                    state_next = ST_P2_EV;
                else
                begin
                    stat_next  = STAT_FULL;
                    state_next = ST_FINISH;
                end
            end
            ST_P2_EV:
            begin
                if (dst.run_hit)
                begin
                    cmd.mark_init = 1'b1;
                    state_next    = ST_MARK;
                end
                else
                begin
                    cmd.ev_alloc = 1'b1;
                    state_next   = ST_P2_RD;
                end
            end
            ST_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (dst.mark_last)
                    state_next = ST_FINISH;
            end
            ST_OP_RD:
            begin
                if (dst.f_end)
                    state_next = ST_FINISH;
                else
                    state_next = ST_OP_EV;
            end
            ST_OP_EV:
            begin
                cmd.ev_op  = 1'b1;
                state_next = ST_OP_RD;
            end
            ST_FINISH:
            begin
                // hold until the output register can take the beat
                if (dst.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/bpfa_dp.sv =====
module bpfa_dp
    import bpfa_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output dstat_t      dst,
    input  logic        cfg_wr,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic [1:0]  kind,
    input  logic [31:0] address,
    input  logic [16:0] page_count,
    input  logic [32:0] byte_length,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic [31:0] alloc_address,
    output logic [16:0] free_frames
);

    localparam int FIDX = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FW   = $clog2(FRAMES + 1);

    logic [1:0]    kind_reg;
    logic [31:0]   addr_reg;
    logic [16:0]   count_reg;
    logic [32:0]   len_reg;
    logic [CW-1:0] f_reg;
    logic [CW-1:0] hi_reg;
    logic [CW-1:0] at_reg;
    logic [16:0]   run_reg;
    logic [31:0]   res_addr_reg;
    logic [16:0]   hint_reg;
    logic [FW-1:0] total_reg;
    logic [16:0]   ftr_reg;
    logic [16:0]   floor_reg;
    logic          rdata_reg;
    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [31:0]   out_addr_reg;
    logic [16:0]   out_free_reg;

    logic          mem [FRAMES];

    logic [CW-1:0] lim, hint_w, hi2, cnt_w, first, last, free_end, op_end, op_hi;
    logic [33:0]   last_sum;
    logic          set_val, we, wdata;
    logic [16:0]   free_sat;

    always_comb
    begin
        lim      = (CW'(ftr_reg) < CW'(FRAMES)) ? CW'(ftr_reg) : CW'(FRAMES);
        hint_w   = CW'(hint_reg);
        hi2      = (hint_w < lim) ? hint_w : lim;
        cnt_w    = CW'(count_reg);
        first    = CW'(addr_reg[31:PAGE_SHIFT]);
        // round the end of the range up to a frame boundary
        last_sum = {2'b00, addr_reg} + {1'b0, len_reg} + 34'd4095;
        last     = last_sum[33:PAGE_SHIFT];
        free_end = first + cnt_w;
        op_end   = (kind_reg == KIND_FREE) ? free_end : last;
        op_hi    = (op_end < lim) ? op_end : lim;
        set_val  = (kind_reg == KIND_RESERVE);

        dst.kind = kind_reg;
        case (kind_reg)
            KIND_ALLOC:   dst.ign = (count_reg == 17'd0);
            KIND_FREE:    dst.ign = (addr_reg == 32'd0) || (count_reg == 17'd0);
            KIND_RESERVE: dst.ign = (len_reg == 33'd0);
            default:      dst.ign = 1'b1;
        endcase
        dst.p1_ok     = (cnt_w <= lim);
        dst.p2_ok     = (cnt_w <= hi2);
        dst.f_end     = (f_reg >= hi_reg);
        dst.run_hit   = !rdata_reg && (({1'b0, run_reg} + 18'd1) == {1'b0, count_reg});
        dst.mark_last = ((f_reg + CW'(1)) >= hi_reg);
        dst.clr_last  = (f_reg == CW'(FRAMES - 1));
        dst.out_free  = !out_valid_reg || !result_stall;

        we    = cmd.clr_step || cmd.mark_step || (cmd.ev_op && (rdata_reg != set_val));
        wdata = cmd.ev_op ? set_val : 1'b1;

        free_sat = (32'(total_reg) > 32'h1FFFF) ? 17'h1FFFF : 17'(total_reg);
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[f_reg[FIDX-1:0]] <= wdata;
        rdata_reg <= mem[f_reg[FIDX-1:0]];
    end

    // payload, scan and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            addr_reg  <= address;
            count_reg <= page_count;
            len_reg   <= byte_length;
        end
        if (cmd.start_p1 || cmd.start_p2)
            run_reg <= 17'd0;
        else if (cmd.ev_alloc)
            run_reg <= rdata_reg ? 17'd0 : run_reg + 17'd1;
        if (cmd.start_p1)
            hi_reg <= lim;
        else if (cmd.start_p2)
            hi_reg <= hi2;
        else if (cmd.start_op)
            hi_reg <= op_hi;
        else if (cmd.mark_init)
            hi_reg <= f_reg + CW'(1);
        if (cmd.mark_init)
            at_reg <= f_reg + CW'(1) - cnt_w;
        if (cmd.finish)
        begin
            out_status_reg <= cmd.fin_status;
            out_addr_reg   <= res_addr_reg;
            out_free_reg   <= free_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg         <= '0;
            res_addr_reg  <= '0;
            hint_reg      <= 17'(HINT_RESET);
            total_reg     <= '0;
            ftr_reg       <= 17'(TRACK_RESET);
            floor_reg     <= 17'(FLOOR_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (cfg_index == REG_FRAMES_TRACKED)
                    ftr_reg <= cfg_data;
                else if (cfg_index == REG_SEARCH_FLOOR)
                    floor_reg <= cfg_data;
            end

            if (cmd.load)
                res_addr_reg <= '0;

            if (cmd.start_p1)
                f_reg <= hint_w;
            else if (cmd.start_p2)
                f_reg <= CW'(floor_reg);
            else if (cmd.start_op)
                f_reg <= first;
            else if (cmd.mark_init)
                f_reg <= f_reg + CW'(1) - cnt_w;
            else if (cmd.ev_alloc || cmd.ev_op || cmd.mark_step || cmd.clr_step)
                f_reg <= f_reg + CW'(1);

            if (cmd.mark_step && dst.mark_last)
            begin
                total_reg    <= total_reg - FW'(count_reg);
                hint_reg     <= 17'(hi_reg);
                res_addr_reg <= {at_reg[31-PAGE_SHIFT:0], {PAGE_SHIFT{1'b0}}};
            end
            else if (cmd.ev_op && we)
            begin
                if (set_val)
                    total_reg <= total_reg - FW'(1);
                else
                    total_reg <= total_reg + FW'(1);
            end

            // free lowers the hint to its first frame
            if (cmd.finish && kind_reg == KIND_FREE && cmd.fin_status == STAT_OK
                && first < hint_w)
                hint_reg <= 17'(first);

            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign result_valid  = out_valid_reg;
    assign status        = out_status_reg;
    assign alloc_address = out_addr_reg;
    assign free_frames   = out_free_reg;

endmodule
